// File: src/assert_macros.svh
// Assertion macros used by the signature search RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication on clock, disabled during reset.
`define WBSS_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("signature search check failed");

// Next-cycle implication on clock, disabled during reset.
`define WBSS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("signature search check failed");

`endif

// File: src/wbss_pkg.sv
// Package: shared constants, register indexes and status codes of the signature search.
`default_nettype none

package wbss_pkg;

   // Default sizes
   localparam int PATTERN_MAX_DEF = 24;
   localparam int OFFSET_BITS_DEF = 32;

   // Signature bytes held in the pattern registers
   localparam int REG_BYTES = 24;

   // Fixed field widths
   localparam int SEEN_W        = 33;
   localparam int ADDR_W        = 48;
   localparam int CSR_DATA_W    = 64;
   localparam int CSR_INDEX_W   = 3;
   localparam int LENGTH_REG_W  = 5;

   // Register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PAT_LOW  = 3'd0,
      CSR_PAT_MID  = 3'd1,
      CSR_PAT_HIGH = 3'd2,
      CSR_CARE     = 3'd3,
      CSR_LENGTH   = 3'd4,
      CSR_BASE     = 3'd5
   } csr_index_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_UNIQUE  = 2'd0,
      ST_NONE    = 2'd1,
      ST_SEVERAL = 2'd2,
      ST_SHORT   = 2'd3
   } scan_status_type;

endpackage

`default_nettype wire

// File: src/wildcard_byte_signature_search.sv
// Top level: streaming wildcard byte signature search with one result per segment.
//
// Use: bytes of a segment enter on the req_ channel (valid/ready), one byte
// per item, req_last_byte marking the final byte. For each segment one
// result item leaves on the rsp_ channel: status, matched address
// (segment base plus match offset, only for a unique match) and the match
// count saturated at two. Registers are written through the csr_ port
// (write enable, index, data); the user must write them only while no
// item is in flight, which the block itself does not enforce.
// Throughput: one byte per cycle while req_ready is high; the comparator
// array is combinational and compares the whole window with the signature.
// Path: an accepted final byte sits in the stage register; its result then
// moves to the result register. Reset: registers return to their defaults
// (length 1, all else zero), the match state clears, and the next byte starts
// from an empty window. Stall: a waiting result stays in the result
// register; non-final bytes keep flowing behind it. A further final byte
// waits in the stage register and req_ready drops until the result is taken.
`default_nettype none
`include "assert_macros.svh"

module wildcard_byte_signature_search
   import wbss_pkg::*;
#(
   parameter int PATTERN_MAX = PATTERN_MAX_DEF,
   parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_last_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_scan_status,
   output logic [ADDR_W-1:0]      rsp_match_address,
   output logic [1:0]             rsp_match_count,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int LEN_W = $clog2(PATTERN_MAX + 1);
   localparam int CMP_W = (LEN_W > LENGTH_REG_W) ? LEN_W : LENGTH_REG_W;
   localparam logic [SEEN_W-1:0] SEEN_MAX = '1;

   // Configuration registers
   logic [REG_BYTES-1:0][7:0] pat_ff, pat_in;
   logic [REG_BYTES-1:0]      care_ff, care_in;
   logic [LENGTH_REG_W-1:0]   len_ff, len_in;
   logic [ADDR_W-1:0]         base_ff, base_in;

   // Stage register (window after shift)
   logic                          seg_end_ff, seg_end_in;
   logic                          stg_vld_ff, stg_vld_in;
   logic                          stg_last_ff, stg_last_in;
   logic [PATTERN_MAX-1:0][7:0]   win_ff, win_in;
   logic [SEEN_W-1:0]             seen_ff, seen_in;
   logic [OFFSET_BITS-1:0]        diff_ff, diff_in;

   // Match state
   logic [1:0]             cnt_ff, cnt_in;
   logic [OFFSET_BITS-1:0] off_ff, off_in;

   // Result register
   logic                 rsp_valid_ff, rsp_valid_in;
   scan_status_type      rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]    rsp_addr_ff, rsp_addr_in;
   logic [1:0]           rsp_count_ff, rsp_count_in;

   // Combinational helpers
   logic [CMP_W-1:0]            len_wide;
   logic [LEN_W-1:0]            len_eff;
   logic [SEEN_W-1:0]           len_seen;
   logic [PATTERN_MAX-1:0][7:0] win_base;
   logic [SEEN_W-1:0]           seen_base;
   logic                        req_fire;
   logic                        stg_adv;
   logic                        win_hit;
   logic                        seen_long;
   logic                        hit;
   logic [1:0]                  cnt_new;
   logic [OFFSET_BITS-1:0]      off_new;

   // Register writes
   always_comb begin
      pat_in  = pat_ff;
      care_in = care_ff;
      len_in  = len_ff;
      base_in = base_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_PAT_LOW:  pat_in[7:0]   = csr_wdata;
            CSR_PAT_MID:  pat_in[15:8]  = csr_wdata;
            CSR_PAT_HIGH: pat_in[23:16] = csr_wdata;
            CSR_CARE:     care_in       = csr_wdata[REG_BYTES-1:0];
            CSR_LENGTH:   len_in        = csr_wdata[LENGTH_REG_W-1:0];
            CSR_BASE:     base_in       = csr_wdata[ADDR_W-1:0];
            default:      pat_in        = pat_ff;
         endcase
      end
   end

   // Clamp the length to 1..PATTERN_MAX
   always_comb begin
      len_wide = CMP_W'(len_ff);
      if (len_ff == '0) begin
         len_wide = CMP_W'(1);
      end
      if (len_wide > CMP_W'(PATTERN_MAX)) begin
         len_wide = CMP_W'(PATTERN_MAX);
      end
      len_eff  = LEN_W'(len_wide);
      len_seen = SEEN_W'(len_eff);
   end

   // Handshake: the stage drains unless a final byte meets a full result register
   assign stg_adv   = stg_vld_ff && (!stg_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !stg_vld_ff || stg_adv;
   assign req_fire  = req_valid && req_ready;

   // Shift the byte in; start from an empty window after a segment end
   always_comb begin
      win_base   = seg_end_ff ? '0 : win_ff;
      seen_base  = seg_end_ff ? '0 : seen_ff;
      win_in     = win_ff;
      seen_in    = seen_ff;
      diff_in    = diff_ff;
      stg_last_in = stg_last_ff;
      seg_end_in = seg_end_ff;
      stg_vld_in = stg_adv ? 1'b0 : stg_vld_ff;
      if (req_fire) begin
         win_in[0] = req_data_byte;
         for (int i = 1; i < PATTERN_MAX; i++) begin
            win_in[i] = win_base[i-1];
         end
         if (seen_base == SEEN_MAX) begin
            seen_in = seen_base;
            diff_in = OFFSET_BITS'(SEEN_MAX - len_seen);
         end else begin
            seen_in = seen_base + SEEN_W'(1);
            diff_in = OFFSET_BITS'(seen_base + SEEN_W'(1) - len_seen);
         end
         stg_last_in = req_last_byte;
         seg_end_in  = req_last_byte;
         stg_vld_in  = 1'b1;
      end
   end

   wbss_matcher #(
      .PATTERN_MAX (PATTERN_MAX),
      .LEN_W       (LEN_W)
   ) u_matcher (
      .window  (win_ff),
      .pattern (pat_ff),
      .care    (care_ff),
      .len_eff (len_eff),
      .hit     (win_hit)
   );

   // Count matches, keep the first offset, build the result on a final byte
   always_comb begin
      seen_long = (seen_ff >= len_seen);
      hit       = seen_long && (cnt_ff != 2'd2) && win_hit;
      cnt_new   = cnt_ff + {1'b0, hit};
      off_new   = (hit && (cnt_ff == 2'd0)) ? diff_ff : off_ff;

      cnt_in        = cnt_ff;
      off_in        = off_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      if (stg_adv) begin
         if (stg_last_ff) begin
            cnt_in       = 2'd0;
            off_in       = '0;
            rsp_valid_in = 1'b1;
            rsp_addr_in  = '0;
            rsp_count_in = cnt_new;
            if (!seen_long) begin
               rsp_status_in = ST_SHORT;
               rsp_count_in  = 2'd0;
            end else if (cnt_new == 2'd1) begin
               rsp_status_in = ST_UNIQUE;
               rsp_addr_in   = base_ff + ADDR_W'(off_new);
            end else if (cnt_new == 2'd0) begin
               rsp_status_in = ST_NONE;
            end else begin
               rsp_status_in = ST_SEVERAL;
            end
         end else begin
            cnt_in = cnt_new;
            off_in = off_new;
         end
      end
   end

   // Control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff       <= '0;
         care_ff      <= '0;
         len_ff       <= LENGTH_REG_W'(1);
         base_ff      <= '0;
         seg_end_ff   <= 1'b1;
         stg_vld_ff   <= 1'b0;
         stg_last_ff  <= 1'b0;
         cnt_ff       <= 2'd0;
         off_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pat_ff       <= pat_in;
         care_ff      <= care_in;
         len_ff       <= len_in;
         base_ff      <= base_in;
         seg_end_ff   <= seg_end_in;
         stg_vld_ff   <= stg_vld_in;
         stg_last_ff  <= stg_last_in;
         cnt_ff       <= cnt_in;
         off_ff       <= off_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      win_ff        <= win_in;
      seen_ff       <= seen_in;
      diff_ff       <= diff_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_scan_status   = rsp_status_ff;
   assign rsp_match_address = rsp_addr_ff;
   assign rsp_match_count   = rsp_count_ff;

   // Checks
   `WBSS_ASSERT_IMP(a_addr_only_unique, rsp_valid_ff && (rsp_addr_ff != '0), rsp_status_ff == ST_UNIQUE)
   `WBSS_ASSERT_IMP(a_unique_counts_one, rsp_valid_ff && (rsp_status_ff == ST_UNIQUE), rsp_count_ff == 2'd1)
   `WBSS_ASSERT_IMP(a_short_no_count, rsp_valid_ff && (rsp_status_ff == ST_SHORT), rsp_count_ff == 2'd0)
   `WBSS_ASSERT_NEXT(a_last_held, stg_vld_ff && stg_last_ff && !stg_adv, stg_vld_ff && stg_last_ff)

endmodule

`default_nettype wire

// File: src/wbss_matcher.sv
// Masked comparator array: tests the byte window against the signature.
`default_nettype none

module wbss_matcher
   import wbss_pkg::*;
#(
   parameter int PATTERN_MAX = PATTERN_MAX_DEF,
   parameter int LEN_W       = $clog2(PATTERN_MAX_DEF + 1)
) (
   input  logic [PATTERN_MAX-1:0][7:0] window,
   input  logic [REG_BYTES-1:0][7:0]   pattern,
   input  logic [REG_BYTES-1:0]        care,
   input  logic [LEN_W-1:0]            len_eff,
   output logic                        hit
);

   // Signature bytes that can take part; higher ones are wildcards
   localparam int KMAX = (PATTERN_MAX < REG_BYTES) ? PATTERN_MAX : REG_BYTES;

   // Signature byte k lines up with window entry len-1-k (entry 0 is newest)
   always_comb begin
      logic [7:0] sel;
      hit = 1'b1;
      for (int k = 0; k < KMAX; k++) begin
         sel = 8'd0;
         for (int j = 0; j < PATTERN_MAX; j++) begin
            if ((j + k + 1) == int'(len_eff)) begin
               sel = sel | window[j];
            end
         end
         if ((k < int'(len_eff)) && care[k] && (sel != pattern[k])) begin
            hit = 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

// File: verif/testbench.sv
// Testbench for the wildcard byte signature search: random byte segments checked against a predictor.
module testbench;
   import wbss_pkg::*;

   localparam int WINDOW_DEPTH = PATTERN_MAX_DEF;
   localparam logic [SEEN_W-1:0] SEEN_LIMIT = '1;
   localparam int CLOCK_HALF = 6;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int BYTE_TARGET = 1250;
   localparam int QUIET_TAIL = 200;
   localparam int SETTLE_CYCLES = 6;
   localparam int LIMIT_CYCLES = 400000;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } stream_byte_type;

   typedef struct {
      scan_status_type     status;
      logic [ADDR_W-1:0]   address;
      logic [1:0]          count;
   } scan_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [7:0]             req_data_byte = '0;
   logic                   req_last_byte = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [1:0]             rsp_scan_status;
   logic [ADDR_W-1:0]      rsp_match_address;
   logic [1:0]             rsp_match_count;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Register copies, reset values
   logic [63:0]       sig_low = '0;
   logic [63:0]       sig_mid = '0;
   logic [63:0]       sig_high = '0;
   logic [23:0]       care_bits = '0;
   logic [4:0]        length_reg = 5'd1;
   logic [ADDR_W-1:0] base_addr = '0;

   // Scan state of the predictor
   logic [7:0]        window_bytes [WINDOW_DEPTH];
   logic [SEEN_W-1:0] seen_count;
   logic [1:0]        hit_count;
   logic [31:0]       first_hit_offset;

   stream_byte_type pending_bytes [$];
   scan_result_type expected_scans [$];
   scan_result_type scan_due;

   bit req_taken = 1'b0;
   bit gaps_on = 1'b1;
   bit long_hold_request = 1'b0;
   int send_gap = 0;
   int hold_left = 0;
   int bytes_queued = 0;
   int bytes_accepted = 0;
   int scans_checked = 0;
   int settings_used = 0;
   int input_stall_cycles = 0;
   int error_count = 0;

   wildcard_byte_signature_search dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_scan_status   (rsp_scan_status),
      .rsp_match_address (rsp_match_address),
      .rsp_match_count   (rsp_match_count),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      forever #CLOCK_HALF clock = ~clock;
   end

   // Clamp the length register to 1..WINDOW_DEPTH
   function automatic int active_length();
      if (length_reg == 0) return 1;
      if (length_reg > WINDOW_DEPTH) return WINDOW_DEPTH;
      return int'(length_reg);
   endfunction

   function automatic logic [7:0] signature_byte(int k);
      logic [63:0] word;
      word = (k < 8) ? sig_low : (k < 16) ? sig_mid : sig_high;
      return word[(k % 8) * 8 +: 8];
   endfunction

   function automatic void clear_scan();
      foreach (window_bytes[i]) window_bytes[i] = '0;
      seen_count = '0;
      hit_count = '0;
      first_hit_offset = '0;
   endfunction

   // Shift one byte into the window, test it, and queue the result on a segment end
   function automatic void track_byte(logic [7:0] data, logic last);
      int len;
      int i;
      int k;
      bit hit;
      scan_result_type res;
      len = active_length();
      for (i = WINDOW_DEPTH - 1; i > 0; i--) window_bytes[i] = window_bytes[i - 1];
      window_bytes[0] = data;
      if (seen_count != SEEN_LIMIT) seen_count++;
      if (seen_count >= len && hit_count < 2) begin
         hit = 1'b1;
         for (k = 0; k < len; k++) begin
            if (care_bits[k] && window_bytes[len - 1 - k] != signature_byte(k)) hit = 1'b0;
         end
         if (hit) begin
            if (hit_count == 0) first_hit_offset = 32'(seen_count - SEEN_W'(len));
            hit_count++;
         end
      end
      if (last) begin
         res.address = '0;
         if (seen_count < len) begin
            res.status = ST_SHORT;
            res.count = '0;
         end else begin
            res.count = hit_count;
            if (hit_count == 0) begin
               res.status = ST_NONE;
            end else if (hit_count == 1) begin
               res.status = ST_UNIQUE;
               res.address = base_addr + ADDR_W'(first_hit_offset);
            end else begin
               res.status = ST_SEVERAL;
            end
         end
         expected_scans.push_back(res);
         clear_scan();
      end
   endfunction

   // Record accepted bytes and check results at the rising edge
   always @(posedge clock) begin
      req_taken = !reset && req_valid && req_ready;
      if (!reset && req_valid && !req_ready) input_stall_cycles++;
      if (req_taken) begin
         track_byte(req_data_byte, req_last_byte);
         bytes_accepted++;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_scans.size() == 0) begin
            $error("scan result with no segment end waiting: status %0d", rsp_scan_status);
            error_count++;
         end else begin
            scan_due = expected_scans.pop_front();
            if (rsp_scan_status !== scan_due.status) begin
               $error("scan_status: expected %0d, got %0d", scan_due.status, rsp_scan_status);
               error_count++;
            end
            if (rsp_match_address !== scan_due.address) begin
               $error("match_address: expected %h, got %h", scan_due.address,
                      rsp_match_address);
               error_count++;
            end
            if (rsp_match_count !== scan_due.count) begin
               $error("match_count: expected %0d, got %0d", scan_due.count, rsp_match_count);
               error_count++;
            end
            scans_checked++;
         end
      end
   end

   // Offer the next item at the falling edge; hold while not yet accepted
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_taken)) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_bytes.size() == 0) begin
            req_valid <= 1'b0;
         end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(0, 8);
            req_valid <= 1'b0;
         end else begin
            req_valid <= 1'b1;
            req_data_byte <= pending_bytes[0].data;
            req_last_byte <= pending_bytes[0].last;
            void'(pending_bytes.pop_front());
         end
      end
   end

   // Stall the result side in bursts, and once for a long stretch
   always @(negedge clock) begin
      if (long_hold_request) begin
         hold_left = LONG_HOLD_CYCLES;
         long_hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
         hold_left = $urandom_range(0, 8);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic write_reg(csr_index_type idx, logic [63:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_PAT_LOW:  sig_low = value;
         CSR_PAT_MID:  sig_mid = value;
         CSR_PAT_HIGH: sig_high = value;
         CSR_CARE:     care_bits = value[23:0];
         CSR_LENGTH:   length_reg = value[4:0];
         CSR_BASE:     base_addr = value[ADDR_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Wait until every byte is taken and every result is back, then let the pipe drain
   task automatic wait_idle();
      do @(posedge clock);
      while (pending_bytes.size() != 0 || req_valid || expected_scans.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Queue n bytes of a word, lowest byte first
   task automatic queue_word(logic [63:0] word, int n, bit close);
      int k;
      for (k = 0; k < n; k++) begin
         pending_bytes.push_back(stream_byte_type'{data: word[k * 8 +: 8],
                                                   last: close && k == n - 1});
      end
      bytes_queued += n;
   endtask

   // Random segment with the signature planted at random spots
   task automatic queue_segment(int seg_len, int plants, bit close);
      logic [7:0] body [];
      int len;
      int pos;
      int n;
      int k;
      len = active_length();
      body = new[seg_len];
      foreach (body[i]) body[i] = 8'($urandom);
      if (seg_len >= len) begin
         for (n = 0; n < plants; n++) begin
            pos = $urandom_range(0, seg_len - len);
            for (k = 0; k < len; k++) begin
               if (care_bits[k]) body[pos + k] = signature_byte(k);
            end
         end
      end
      for (k = 0; k < seg_len; k++) begin
         pending_bytes.push_back(stream_byte_type'{data: body[k],
                                                   last: close && k == seg_len - 1});
      end
      bytes_queued += seg_len;
   endtask

   // Pick a new setting for every register; force_len >= 0 overrides the length
   task automatic random_settings(int force_len);
      logic [63:0] words [3];
      logic [23:0] care;
      logic [4:0]  len;
      logic [47:0] base;
      int i;
      for (i = 0; i < 3; i++) begin
         case ($urandom_range(0, 7))
            0:       words[i] = '0;
            1:       words[i] = '1;
            default: words[i] = {$urandom, $urandom};
         endcase
      end
      case ($urandom_range(0, 9))
         0:       care = '0;
         1:       care = '1;
         2:       care = 24'($urandom) & 24'($urandom);
         default: care = 24'($urandom) | 24'($urandom);
      endcase
      case ($urandom_range(0, 9))
         0:       len = 5'd0;
         1, 2:    len = 5'(WINDOW_DEPTH);
         3:       len = 5'($urandom_range(WINDOW_DEPTH + 1, 31));
         default: len = 5'($urandom_range(1, 8));
      endcase
      if (force_len >= 0) len = 5'(force_len);
      case ($urandom_range(0, 4))
         0:       base = '0;
         1:       base = '1;
         default: base = {16'($urandom), $urandom};
      endcase
      write_reg(CSR_PAT_LOW, words[0]);
      write_reg(CSR_PAT_MID, words[1]);
      write_reg(CSR_PAT_HIGH, words[2]);
      write_reg(CSR_CARE, {$urandom, 8'($urandom), care});
      write_reg(CSR_LENGTH, {$urandom, 27'($urandom), len});
      write_reg(CSR_BASE, {16'($urandom), base});
      settings_used++;
   endtask

   initial begin
      int phase;
      int segs;
      int s;
      int seg_len;
      int plants;
      int pick;
      int force_len;
      bit close;

      clear_scan();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      settings_used = 1;

      // Reset defaults: one-byte signature, all wildcard, so every byte is a hit
      queue_word(64'h00, 1, 1'b1);
      queue_word(64'h80FF, 2, 1'b1);
      wait_idle();

      // DE AD ?? EF with byte 2 a wildcard, base near the top of the address space
      write_reg(CSR_PAT_LOW, 64'h0000_0000_EFBE_ADDE);
      write_reg(CSR_PAT_MID, '1);
      write_reg(CSR_PAT_HIGH, '1);
      write_reg(CSR_CARE, 64'h0000_0000_0000_000B);
      write_reg(CSR_LENGTH, 64'd4);
      write_reg(CSR_BASE, 64'h0000_FFFF_FFFF_FFFE);
      settings_used++;
      @(posedge clock);
      // segment shorter than the signature
      queue_word(64'hADDE, 2, 1'b1);
      // unique hit at offset 3, address wraps past the top
      queue_word(64'h00EF_00AD_DE33_2211, 7, 1'b1);
      // two hits
      queue_word(64'hEF00_ADDE_EFFF_ADDE, 8, 1'b0);
      queue_word(64'hFF, 1, 1'b1);
      // no hit
      queue_word(64'hFFFF_FFFF, 4, 1'b1);
      wait_idle();

      // Random phases: new settings, then a batch of segments
      phase = 0;
      while (bytes_queued < BYTE_TARGET) begin
         case (phase)
            0:       force_len = 0;
            1:       force_len = 31;
            2:       force_len = WINDOW_DEPTH;
            default: force_len = -1;
         endcase
         random_settings(force_len);
         @(posedge clock);
         gaps_on = bytes_queued < BYTE_TARGET - QUIET_TAIL;
         if (phase == 3) begin
            // fill the pipe with short segments while results are held back
            long_hold_request = 1'b1;
            for (s = 0; s < 40; s++) queue_segment($urandom_range(1, 3), 1, 1'b1);
         end else begin
            segs = $urandom_range(3, 8);
            for (s = 0; s < segs; s++) begin
               if ($urandom_range(0, 9) == 0) seg_len = $urandom_range(1, 60);
               else seg_len = $urandom_range(1, active_length() + 10);
               pick = $urandom_range(0, 9);
               plants = (pick < 6) ? 1 : (pick < 8) ? 0 : 2;
               // leave the last segment open now and then, so new settings land mid-segment
               close = !(s == segs - 1 && bytes_queued < BYTE_TARGET - 300 &&
                         (phase == 0 || $urandom_range(0, 3) == 0));
               queue_segment(seg_len, plants, close);
            end
         end
         wait_idle();
         phase++;
      end

      $display("Scanned %0d bytes under %0d register settings, %0d segment results checked.",
               bytes_accepted, settings_used, scans_checked);
      $display("Input was held back by a full pipeline for %0d cycles.", input_stall_cycles);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Give up on a hung run
   initial begin
      #(2 * CLOCK_HALF * LIMIT_CYCLES);
      $display("FAIL");
      $finish;
   end

endmodule

// File: sim.f
+incdir+src
src/wbss_pkg.sv
src/wbss_matcher.sv
src/wildcard_byte_signature_search.sv
verif/testbench.sv
